### src/xmodem_checksum_receiver_defines.svh
// assertion macros used by the xmodem checksum receiver rtl
`ifndef XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH
`define XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define XCR_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("xcr check failed");

// next-cycle implication, sampled on clk, off during rst
`define XCR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("xcr check failed");

`endif

### src/xcr_pkg.sv
// shared types and constants of the xmodem checksum receiver
package xcr_pkg;

  localparam int unsigned DATA_LEN  = 128;
  localparam int unsigned FRAME_LEN = DATA_LEN + 4;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [8:0] HDR_SUM  = 9'h0ff;

  localparam logic [7:0] POS_SOH  = 8'd0;
  localparam logic [7:0] POS_BLK  = 8'd1;
  localparam logic [7:0] POS_NBLK = 8'd2;
  localparam logic [7:0] POS_CSUM = 8'(FRAME_LEN - 1);

  localparam logic [1:0] PHASE_ASK   = 2'd0;
  localparam logic [1:0] PHASE_DATA  = 2'd1;
  localparam logic [1:0] PHASE_FRAME = 2'd2;
  localparam logic [1:0] PHASE_END   = 2'd3;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NAK  = 2'd2;

  localparam logic [1:0] REG_AUTO_ACK   = 2'd0;
  localparam logic [1:0] REG_STORE_MODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  typedef enum logic {
    KIND_TICK,
    KIND_BYTE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       auto_ack;
    logic       store_mode;
    logic [7:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  reply;
    logic        frame_done;
    logic        frame_good;
    logic [7:0]  block_number;
    logic [19:0] dest_offset;
    logic [15:0] good_frames;
    logic [15:0] nak_frames;
  } res_t;

endpackage

### src/xcr_front.sv
// front end: classifies incoming requests and queues them for the engine
module xcr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          op,
  input  logic [7:0]    rx_byte,
  input  logic          chunk_end,
  output logic          cmd_valid,
  output xcr_pkg::cmd_t cmd,
  input  logic          cmd_take
);

  xcr_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          wr_en;
  logic          rd_en;
  xcr_pkg::cmd_t cls;

  // ticks carry no byte and never close a chunk
  always_comb begin
    cls.kind = op ? xcr_pkg::KIND_BYTE : xcr_pkg::KIND_TICK;
    cls.data = op ? rx_byte : 8'h00;
    cls.last = op & chunk_end;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign wr_en     = push & ~full;
  assign rd_en     = cmd_take & cmd_valid;
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

### src/xcr_back.sv
// back end: frame state, checksum check and reply generation
`include "xmodem_checksum_receiver_defines.svh"

module xcr_back #(
  parameter int unsigned LAST_CHUNK_LEN = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  xcr_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  xcr_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output xcr_pkg::res_t res,
  input  logic          res_full
);

  logic [1:0]  phase_reg, phase_reg_next;
  logic [7:0]  idle_ticks, idle_ticks_next;
  logic [7:0]  line_pos, line_pos_next;
  logic [7:0]  chunk_len, chunk_len_next;
  logic [7:0]  data_sum, data_sum_next;
  logic [15:0] good_count, good_count_next;
  logic [15:0] bad_count, bad_count_next;
  logic [19:0] offset_reg, offset_reg_next;
  logic        last_result, last_result_next;
  logic [7:0]  last_block, last_block_next;
  logic [7:0]  soh_b, soh_b_next;
  logic [7:0]  blk_b, blk_b_next;
  logic [7:0]  nblk_b, nblk_b_next;
  logic [7:0]  csum_b, csum_b_next;
  logic [1:0]  reply;
  logic        done;
  logic        ok;
  logic        step;

  assign step      = cmd_valid & ~res_full;
  assign cmd_take  = step;
  assign res_valid = step;

  always_comb begin
    phase_reg_next   = phase_reg;
    idle_ticks_next  = idle_ticks;
    line_pos_next    = line_pos;
    chunk_len_next   = chunk_len;
    data_sum_next    = data_sum;
    good_count_next  = good_count;
    bad_count_next   = bad_count;
    offset_reg_next  = offset_reg;
    last_result_next = last_result;
    last_block_next  = last_block;
    soh_b_next       = soh_b;
    blk_b_next       = blk_b;
    nblk_b_next      = nblk_b;
    csum_b_next      = csum_b;
    reply            = xcr_pkg::REPLY_NONE;
    done             = 1'b0;
    ok               = 1'b0;
    if (step) begin
      if (cmd.kind == xcr_pkg::KIND_TICK) begin
        if (idle_ticks > cfg.timeout_limit) begin
          phase_reg_next  = xcr_pkg::PHASE_ASK;
          reply           = xcr_pkg::REPLY_NAK;
          idle_ticks_next = 8'd0;
          line_pos_next   = 8'd0;
          chunk_len_next  = 8'd0;
          data_sum_next   = 8'd0;
          good_count_next = 16'd0;
        end else if (idle_ticks != 8'hff) begin
          idle_ticks_next = idle_ticks + 8'd1;
        end
      end else begin
        phase_reg_next  = xcr_pkg::PHASE_DATA;
        idle_ticks_next = 8'd0;
        // only header bytes and the checksum byte are kept
        if (line_pos < 8'(xcr_pkg::FRAME_LEN)) begin
          case (line_pos)
            xcr_pkg::POS_SOH:  soh_b_next  = cmd.data;
            xcr_pkg::POS_BLK:  blk_b_next  = cmd.data;
            xcr_pkg::POS_NBLK: nblk_b_next = cmd.data;
            xcr_pkg::POS_CSUM: csum_b_next = cmd.data;
            default: begin
              data_sum_next = data_sum + cmd.data;
            end
          endcase
          line_pos_next = line_pos + 8'd1;
        end
        chunk_len_next = (chunk_len == 8'hff) ? 8'hff : chunk_len + 8'd1;
        if (cmd.last) begin
          if (chunk_len_next == 8'(LAST_CHUNK_LEN)) begin
            done            = 1'b1;
            last_block_next = blk_b_next;
            ok = (soh_b_next == xcr_pkg::SOH_BYTE) &&
                 (({1'b0, blk_b_next} + {1'b0, nblk_b_next}) == xcr_pkg::HDR_SUM) &&
                 (data_sum_next == csum_b_next);
            last_result_next = ok;
            if (ok) begin
              good_count_next = good_count + 16'd1;
              if (cfg.store_mode) begin
                offset_reg_next = offset_reg + 20'(xcr_pkg::DATA_LEN);
              end
              if (cfg.auto_ack) begin
                reply = xcr_pkg::REPLY_ACK;
              end
            end else begin
              bad_count_next = bad_count + 16'd1;
              reply          = xcr_pkg::REPLY_NAK;
            end
            line_pos_next  = 8'd0;
            data_sum_next  = 8'd0;
            phase_reg_next = xcr_pkg::PHASE_FRAME;
          end else if (chunk_len_next == 8'd1) begin
            if (cfg.auto_ack) begin
              reply = xcr_pkg::REPLY_ACK;
            end
            line_pos_next  = 8'd0;
            data_sum_next  = 8'd0;
            phase_reg_next = xcr_pkg::PHASE_END;
          end
          chunk_len_next = 8'd0;
        end
      end
    end
    res.phase        = phase_reg_next;
    res.reply        = reply;
    res.frame_done   = done;
    res.frame_good   = last_result_next;
    res.block_number = last_block_next;
    res.dest_offset  = offset_reg;
    res.good_frames  = good_count_next;
    res.nak_frames   = bad_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= xcr_pkg::PHASE_ASK;
      idle_ticks  <= 8'd0;
      line_pos    <= 8'd0;
      chunk_len   <= 8'd0;
      data_sum    <= 8'd0;
      good_count  <= 16'd0;
      bad_count   <= 16'd0;
      offset_reg  <= 20'd0;
      last_result <= 1'b0;
      last_block  <= 8'd0;
    end else begin
      phase_reg   <= phase_reg_next;
      idle_ticks  <= idle_ticks_next;
      line_pos    <= line_pos_next;
      chunk_len   <= chunk_len_next;
      data_sum    <= data_sum_next;
      good_count  <= good_count_next;
      bad_count   <= bad_count_next;
      offset_reg  <= offset_reg_next;
      last_result <= last_result_next;
      last_block  <= last_block_next;
    end
  end

  // header and checksum bytes, held without reset
  always_ff @(posedge clk) begin
    soh_b  <= soh_b_next;
    blk_b  <= blk_b_next;
    nblk_b <= nblk_b_next;
    csum_b <= csum_b_next;
  end

  `XCR_ASSERT_NOW(a_pos_bound, 1'b1, line_pos <= 8'(xcr_pkg::FRAME_LEN))
  `XCR_ASSERT_NOW(a_done_phase, step && done, res.phase == xcr_pkg::PHASE_FRAME)
  `XCR_ASSERT_NEXT(a_timeout_clear,
    step && cmd.kind == xcr_pkg::KIND_TICK && idle_ticks > cfg.timeout_limit,
    line_pos == 8'd0 && good_count == 16'd0 && data_sum == 8'd0)
  `XCR_ASSERT_NEXT(a_bad_only_on_nak, !(step && done && !ok),
    bad_count == $past(bad_count))

endmodule

### src/xcr_resq.sv
// result queue between the engine and the result port
module xcr_resq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  xcr_pkg::res_t wr_data,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output xcr_pkg::res_t rd_data
);

  xcr_pkg::res_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          wr_en;
  logic          rd_en;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign wr_en   = wr_valid & ~full;
  assign rd_en   = pop & ~empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

### src/xmodem_checksum_receiver.sv
// top level of the xmodem checksum receiver with its register port
// usage
// - request channel: push with full; a request is a timer tick (op low) or a
//   received byte (op high) with chunk_end marking the last byte of a chunk
// - result channel: empty with pop; exactly one result per request, in order
// - register port: apb-style, auto_ack at 0x0, store_mode at 0x4,
//   timeout_limit at 0x8; write only while no request is in flight
// - path: a request is registered in the request queue, passes through the
//   frame engine and is registered in the result queue, ready to pop
// - throughput: one request per cycle while the result queue has room
// - a two-entry request queue sits in front of the engine and a two-entry
//   result queue behind it, so either side can stall on its own
// - when the result side stalls, results fill the result queue, then the
//   request queue, then full rises; nothing is lost
// - reset clears frame state, counters, offset and both queues; registers
//   return to auto_ack set, store_mode clear, timeout_limit ten
// - no clearing pass is needed after reset
module xmodem_checksum_receiver #(
  parameter int unsigned LAST_CHUNK_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  input  logic        chunk_end,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  phase,
  output logic [1:0]  reply,
  output logic        frame_done,
  output logic        frame_good,
  output logic [7:0]  block_number,
  output logic [19:0] dest_offset,
  output logic [15:0] good_frames,
  output logic [15:0] nak_frames,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  xcr_pkg::cfg_t cfg;
  xcr_pkg::cmd_t cmd;
  xcr_pkg::res_t eng_res;
  xcr_pkg::res_t out_res;
  logic          cmd_valid;
  logic          cmd_take;
  logic          res_valid;
  logic          res_full;
  logic          reg_wr;
  logic [1:0]    reg_idx;

  // register port: zero wait states, word index from the byte address
  assign pready  = 1'b1;
  assign reg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_ack      <= 1'b1;
      cfg.store_mode    <= 1'b0;
      cfg.timeout_limit <= 8'd10;
    end else if (reg_wr) begin
      unique case (reg_idx)
        xcr_pkg::REG_AUTO_ACK:   cfg.auto_ack      <= pwdata[0];
        xcr_pkg::REG_STORE_MODE: cfg.store_mode    <= pwdata[0];
        xcr_pkg::REG_TIMEOUT:    cfg.timeout_limit <= pwdata[7:0];
        default: begin
          // unmapped word, write dropped
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      xcr_pkg::REG_AUTO_ACK:   prdata = {31'd0, cfg.auto_ack};
      xcr_pkg::REG_STORE_MODE: prdata = {31'd0, cfg.store_mode};
      xcr_pkg::REG_TIMEOUT:    prdata = {24'd0, cfg.timeout_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  // front: classify and queue requests
  xcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .rx_byte   (rx_byte),
    .chunk_end (chunk_end),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: frame engine, one request per cycle when the result queue has room
  xcr_back #(
    .LAST_CHUNK_LEN (LAST_CHUNK_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (eng_res),
    .res_full  (res_full)
  );

  // result queue feeding the result ports
  xcr_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (eng_res),
    .full     (res_full),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (out_res)
  );

  assign phase        = out_res.phase;
  assign reply        = out_res.reply;
  assign frame_done   = out_res.frame_done;
  assign frame_good   = out_res.frame_good;
  assign block_number = out_res.block_number;
  assign dest_offset  = out_res.dest_offset;
  assign good_frames  = out_res.good_frames;
  assign nak_frames   = out_res.nak_frames;

endmodule
